[hdl/stt_pkg.sv]
// Shared types and codes for the segment table translate block.
// Used by stt_ctrl, stt_datapath and segment_table_translate; depends on nothing.
package stt_pkg;

  // Kind of input item, carried in s_axis_tuser
  typedef enum logic {
    CMD_INSERT    = 1'b0,
    CMD_TRANSLATE = 1'b1
  } cmd_e;

  // Result status codes, carried in m_axis_tuser
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_LIMIT     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  // Which result the datapath latches in a cycle
  typedef enum logic [2:0] {
    RES_NONE,
    RES_STORED,
    RES_FULL,
    RES_MISS,
    RES_LOOKUP
  } res_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     write_entry;
    logic     inc_idx;
    logic     rd_en;
    res_sel_e res_sel;
    logic     load_out;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic hit;
    logic last_entry;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/stt_ctrl.sv]
// Sequencing state machine for the segment table translate block.
// Depends on stt_pkg for the state, command and status types.
module stt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  stt_pkg::dp_status_t status_i,
  output stt_pkg::dp_cmd_t    cmd_o
);
  import stt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status_i.cmd == CMD_INSERT || status_i.empty) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.hit || status_i.last_entry) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '{capture: 1'b0, write_entry: 1'b0, inc_idx: 1'b0, rd_en: 1'b0,
                      res_sel: RES_NONE, load_out: 1'b0};
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.capture = s_axis_tvalid;
      end
      ST_DISPATCH: begin
        if (status_i.cmd == CMD_INSERT) begin
          if (status_i.full) begin
            cmd_o.res_sel = RES_FULL;
          end else begin
            cmd_o.write_entry = 1'b1;
            cmd_o.res_sel     = RES_STORED;
          end
        end else if (status_i.empty) begin
          cmd_o.res_sel = RES_MISS;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_CHECK: begin
        if (status_i.hit) begin
          cmd_o.res_sel = RES_LOOKUP;
        end else if (status_i.last_entry) begin
          cmd_o.res_sel = RES_MISS;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

endmodule

[hdl/stt_datapath.sv]
// Table storage, scan pointer, limit check and result register for the block.
// Depends on stt_pkg; driven by stt_ctrl through dp_cmd_t.
module stt_datapath #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ADDRESS_BITS  = 32,
  parameter int SEGMENT_BITS  = 8,
  parameter int IN_W          = 104,
  parameter int OUT_W         = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IN_W-1:0]       s_axis_tdata,
  input  logic                  s_axis_tuser,
  output logic [OUT_W-1:0]      m_axis_tdata,
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  stt_pkg::dp_cmd_t      cmd_i,
  output stt_pkg::dp_status_t   status_o
);
  import stt_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int PA_W   = ADDRESS_BITS + 1;

  // Captured item
  cmd_e                    cmd_q;
  logic [SEGMENT_BITS-1:0] seg_q;
  logic [ADDRESS_BITS-1:0] base_q;
  logic [ADDRESS_BITS-1:0] limit_q;
  logic [ADDRESS_BITS-1:0] offset_q;

  // Table memories, no reset: only entries below fill_q are ever read
  logic [SEGMENT_BITS-1:0] seg_mem   [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0] base_mem  [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0] limit_mem [TABLE_ENTRIES];

  logic [SEGMENT_BITS-1:0] rd_seg_q;
  logic [ADDRESS_BITS-1:0] rd_base_q;
  logic [ADDRESS_BITS-1:0] rd_limit_q;

  logic [FILL_W-1:0] fill_q;
  logic [IDX_W-1:0]  idx_q;

  logic [PA_W-1:0] res_phys_q, res_phys_d;
  status_e         res_status_q, res_status_d;

  logic            m_valid_q;
  logic [PA_W-1:0] m_phys_q;
  status_e         m_status_q;

  logic            out_free;
  logic [PA_W-1:0] sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= cmd_e'(s_axis_tuser);
      seg_q    <= s_axis_tdata[SEGMENT_BITS-1:0];
      base_q   <= s_axis_tdata[SEGMENT_BITS +: ADDRESS_BITS];
      limit_q  <= s_axis_tdata[SEGMENT_BITS + ADDRESS_BITS +: ADDRESS_BITS];
      offset_q <= s_axis_tdata[SEGMENT_BITS + 2*ADDRESS_BITS +: ADDRESS_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) begin
      seg_mem[fill_q[IDX_W-1:0]]   <= seg_q;
      base_mem[fill_q[IDX_W-1:0]]  <= base_q;
      limit_mem[fill_q[IDX_W-1:0]] <= limit_q;
    end
    if (cmd_i.rd_en) begin
      rd_seg_q   <= seg_mem[idx_q];
      rd_base_q  <= base_mem[idx_q];
      rd_limit_q <= limit_mem[idx_q];
    end
  end

  // Fill count and scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.write_entry) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  assign sum = PA_W'(rd_base_q) + PA_W'(offset_q);

  always_comb begin
    res_phys_d   = res_phys_q;
    res_status_d = res_status_q;
    case (cmd_i.res_sel)
      RES_STORED: begin
        res_phys_d   = '0;
        res_status_d = STATUS_OK;
      end
      RES_FULL: begin
        res_phys_d   = '0;
        res_status_d = STATUS_FULL;
      end
      RES_MISS: begin
        res_phys_d   = '0;
        res_status_d = STATUS_NOT_FOUND;
      end
      RES_LOOKUP: begin
        if (offset_q < rd_limit_q) begin
          res_phys_d   = sum;
          res_status_d = STATUS_OK;
        end else begin
          res_phys_d   = '0;
          res_status_d = STATUS_LIMIT;
        end
      end
      default: begin
        res_phys_d = res_phys_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_phys_q   <= res_phys_d;
    res_status_q <= res_status_d;
  end

  // Output register: holds a result while the next item is taken in
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      m_phys_q   <= res_phys_q;
      m_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'(m_phys_q);
  assign m_axis_tuser  = m_status_q;

  assign status_o.cmd        = cmd_q;
  assign status_o.full       = (fill_q == FILL_W'(TABLE_ENTRIES));
  assign status_o.empty      = (fill_q == '0);
  assign status_o.hit        = (rd_seg_q == seg_q);
  assign status_o.last_entry = ((FILL_W'(idx_q) + FILL_W'(1)) == fill_q);
  assign status_o.out_free   = out_free;

endmodule

[hdl/segment_table_translate.sv]
// Top level of the segment table translate block.
// Depends on stt_pkg, stt_ctrl and stt_datapath.
//
// Segment table with base/limit address translation. An insert item
// (s_axis_tuser = 0) stores segment number, base and limit in the next free
// table entry and returns status OK, or status FULL when all TABLE_ENTRIES
// entries are taken (the table is left unchanged). A translate item
// (s_axis_tuser = 1) scans the table in insert order; the oldest entry with
// the same segment number wins. If the offset is strictly below its limit the
// result is base + offset (ADDRESS_BITS+1 bits, no wrap) with status OK,
// otherwise status LIMIT and a zero address; with no matching entry the status
// is NOT_FOUND. Every item yields exactly one result transfer. The block takes
// one item at a time: an insert passes through the dispatch and finish states,
// a translate through dispatch, then a read and a check state for each entry
// examined (up to the first match, or every filled entry on a miss), then
// finish, which waits until the output register is free. The scan reads one
// entry at a time through the single registered read port of the table memory.
// A finished result sits in an output register, so a new input transfer is
// taken while the previous result still waits for m_axis_tready. No clearing
// pass is needed after reset: the fill count marks which entries hold data.
module segment_table_translate #(
  parameter int TABLE_ENTRIES = 16,
  parameter int ADDRESS_BITS  = 32,
  parameter int SEGMENT_BITS  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input item stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, low bit up: segment_number, base_address, segment_limit, offset, zero pad
  input  logic [((SEGMENT_BITS + 3*ADDRESS_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: cmd (0 insert, 1 translate)
  input  logic             s_axis_tuser,
  // Result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // tdata, low bit up: physical_address, zero pad
  output logic [((ADDRESS_BITS + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: status (0 ok, 1 limit fault, 2 not found, 3 table full)
  output logic [1:0]       m_axis_tuser
);
  import stt_pkg::*;

  localparam int IN_W  = ((SEGMENT_BITS + 3*ADDRESS_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((ADDRESS_BITS + 1 + 7) / 8) * 8;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequence insert, scan and result handoff
  stt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (dp_status),
    .cmd_o         (dp_cmd)
  );

  // Hold the table, compare, add and register the result
  stt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDRESS_BITS  (ADDRESS_BITS),
    .SEGMENT_BITS  (SEGMENT_BITS),
    .IN_W          (IN_W),
    .OUT_W         (OUT_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status)
  );

endmodule
